/* sv/erst_pkg.sv */
// erst_pkg: shared types, codes and sizes for the expert residency state table
// no dependencies; imported by every module of the block except erst_ram

package erst_pkg;

  localparam int NUM_LAYERS  = 32;
  localparam int NUM_EXPERTS = 64;
  localparam int NUM_TIERS   = 4;

  localparam int DEPTH = NUM_LAYERS * NUM_EXPERTS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int OP_W     = 4;
  localparam int LAYER_W  = 5;
  localparam int EXPERT_W = 6;
  localparam int TIER_W   = 2;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 32;
  localparam int STAT_W   = 2;
  localparam int LC_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 4'd0,
    OP_REQUEST  = 4'd1,
    OP_QUEUE    = 4'd2,
    OP_LOAD     = 4'd3,
    OP_READY    = 4'd4,
    OP_ACQUIRE  = 4'd5,
    OP_RELEASE  = 4'd6,
    OP_EVICT    = 4'd7,
    OP_FAIL     = 4'd8,
    OP_READ     = 4'd9
  } op_e;

  typedef enum logic [LC_W-1:0] {
    LC_READY     = 3'd0,
    LC_REQUESTED = 3'd1,
    LC_QUEUED    = 3'd2,
    LC_LOADING   = 3'd3,
    LC_IN_USE    = 3'd4,
    LC_EVICTING  = 3'd5,
    LC_FAILED    = 3'd6
  } lc_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOT_REG = 2'd1,
    ST_ALREADY = 2'd2,
    ST_ILLEGAL = 2'd3
  } status_e;

  typedef struct packed {
    logic                valid;
    lc_e                 lc;
    logic [TIER_W-1:0]   cur;
    logic [TIER_W-1:0]   tgt;
    logic [CNT_W-1:0]    usage;
    logic [TIME_W-1:0]   last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // outcome of one operation on one entry
  typedef struct packed {
    logic    we;
    status_e status;
    entry_t  entry;
  } rsp_t;

  function automatic logic [TIER_W-1:0] clamp_tier(input logic [TIER_W-1:0] t);
    logic [TIER_W-1:0] r;
    r = t;
    if (32'(t) >= NUM_TIERS) r = TIER_W'(NUM_TIERS - 1);
    return r;
  endfunction

endpackage

/* sv/erst_ram.sv */
// erst_ram: generic single-write, single-read ram with registered read data
// no dependencies

module erst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/erst_update.sv */
// erst_update: lifecycle transition rules for one table entry
// depends on erst_pkg

module erst_update (
  input  logic [erst_pkg::OP_W-1:0]   op_i,
  input  logic [erst_pkg::TIER_W-1:0] tier_i,
  input  logic [erst_pkg::TIME_W-1:0] now_i,
  input  logic                        in_range_i,
  input  erst_pkg::entry_t            entry_i,
  output erst_pkg::rsp_t              rsp_o
);
  import erst_pkg::*;

  entry_t  e;
  status_e st;

  always_comb begin
    e  = entry_i;
    st = ST_OK;
    if (!in_range_i) begin
      st = ST_NOT_REG;
    end else if (op_e'(op_i) == OP_REGISTER) begin
      if (e.valid) begin
        st = ST_ALREADY;
      end else begin
        e.valid = 1'b1;
        e.lc    = LC_READY;
        e.cur   = tier_i;
        e.tgt   = tier_i;
        e.usage = '0;
        e.last  = now_i;
      end
    end else if (!e.valid) begin
      st = ST_NOT_REG;
    end else begin
      case (op_e'(op_i))
        OP_REQUEST: begin
          if (e.lc == LC_READY || e.lc == LC_FAILED) begin
            e.tgt = tier_i;
            e.lc  = LC_REQUESTED;
          end else st = ST_ILLEGAL;
        end
        OP_QUEUE: begin
          if (e.lc == LC_REQUESTED) e.lc = LC_QUEUED;
          else st = ST_ILLEGAL;
        end
        OP_LOAD: begin
          if (e.lc == LC_QUEUED) e.lc = LC_LOADING;
          else st = ST_ILLEGAL;
        end
        OP_READY: begin
          if (e.lc == LC_LOADING || e.lc == LC_EVICTING || e.lc == LC_REQUESTED) begin
            e.cur  = tier_i;
            e.tgt  = tier_i;
            e.lc   = LC_READY;
            e.last = now_i;
          end else st = ST_ILLEGAL;
        end
        OP_ACQUIRE: begin
          if (e.lc == LC_READY) begin
            e.lc   = LC_IN_USE;
            e.last = now_i;
            // usage count saturates
            if (e.usage != '1) e.usage = e.usage + CNT_W'(1);
          end else st = ST_ILLEGAL;
        end
        OP_RELEASE: begin
          if (e.lc == LC_IN_USE) begin
            e.lc   = LC_READY;
            e.last = now_i;
          end else st = ST_ILLEGAL;
        end
        OP_EVICT: begin
          if (e.lc == LC_READY) begin
            e.tgt = tier_i;
            e.lc  = LC_EVICTING;
          end else st = ST_ILLEGAL;
        end
        OP_FAIL: e.lc = LC_FAILED;
        default: ;  // read and undefined codes leave the entry alone
      endcase
    end

    rsp_o.we     = in_range_i && (st == ST_OK);
    rsp_o.status = st;
    rsp_o.entry  = (st == ST_NOT_REG) ? '0 : e;
  end

endmodule

/* sv/expert_residency_state_table.sv */
// expert_residency_state_table: top level, per (layer, expert) residency table
// depends on erst_pkg, erst_ram, erst_update
//
//  channel   handshake          word
//  -------   ----------------   ------------------------------------------------
//  command   start / busy       opcode_i, layer_i, expert_i, tier_i, now_i
//  result    done_o (strobe)    status_o, lifecycle_o, current_tier_o,
//                               target_tier_o, usage_count_o, last_used_o,
//                               registered_o
//
// one command per cycle while busy is low; its result strobes after the
// table ram read, then the update and result register; a write to the entry
// read by the next command is forwarded, so back-to-back commands work
// after reset busy is high while the clearing pass zeroes every entry of
// the table ram; no commands are taken meanwhile
// results cannot be stalled: done_o is high for exactly one cycle per command

module expert_residency_state_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [erst_pkg::OP_W-1:0]     opcode_i,
  input  logic [erst_pkg::LAYER_W-1:0]  layer_i,
  input  logic [erst_pkg::EXPERT_W-1:0] expert_i,
  input  logic [erst_pkg::TIER_W-1:0]   tier_i,
  input  logic [erst_pkg::TIME_W-1:0]   now_i,
  output logic                          done_o,
  output logic [erst_pkg::STAT_W-1:0]   status_o,
  output logic [erst_pkg::LC_W-1:0]     lifecycle_o,
  output logic [erst_pkg::TIER_W-1:0]   current_tier_o,
  output logic [erst_pkg::TIER_W-1:0]   target_tier_o,
  output logic [erst_pkg::CNT_W-1:0]    usage_count_o,
  output logic [erst_pkg::TIME_W-1:0]   last_used_o,
  output logic                          registered_o
);
  import erst_pkg::*;

  // clearing pass
  logic             clr_q, clr_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;

  // stage 1: command waiting for its ram read data
  logic              s1_vld_q;
  logic [OP_W-1:0]   s1_op_q;
  logic [TIER_W-1:0] s1_tier_q;
  logic [TIME_W-1:0] s1_now_q;
  logic              s1_rng_q;
  logic [IDX_W-1:0]  s1_idx_q;

  // last write, forwarded to a read of the same entry issued in the same cycle
  logic              fwd_vld_q;
  logic [IDX_W-1:0]  fwd_idx_q;
  entry_t            fwd_data_q;

  // result register
  logic              done_q;
  rsp_t              res_q;

  logic              accept;
  logic [31:0]       idx_full;
  logic              in_range;
  logic [IDX_W-1:0]  idx;
  logic [ENTRY_W-1:0] rd_data;
  entry_t            cur_entry;
  rsp_t              rsp;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  assign busy   = clr_q;
  assign accept = start && !clr_q;

  assign idx_full = 32'(int'(layer_i) * NUM_EXPERTS + int'(expert_i));
  assign in_range = (int'(layer_i) < NUM_LAYERS) && (int'(expert_i) < NUM_EXPERTS);
  assign idx      = idx_full[IDX_W-1:0];

  assign cur_entry = (fwd_vld_q && fwd_idx_q == s1_idx_q) ? fwd_data_q : entry_t'(rd_data);

  erst_update u_update (
    .op_i      (s1_op_q),
    .tier_i    (s1_tier_q),
    .now_i     (s1_now_q),
    .in_range_i(s1_rng_q),
    .entry_i   (cur_entry),
    .rsp_o     (rsp)
  );

  always_comb begin
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_vld_q && rsp.we;
      ram_waddr = s1_idx_q;
      ram_wdata = rsp.entry;
    end
  end

  erst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(idx),
    .rdata_o(rd_data)
  );

  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + IDX_W'(1);
      if (clr_idx_q == IDX_W'(DEPTH - 1)) clr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
      s1_vld_q  <= accept;
      fwd_vld_q <= s1_vld_q && rsp.we;
      done_q    <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= opcode_i;
      s1_tier_q <= clamp_tier(tier_i);
      s1_now_q  <= now_i;
      s1_rng_q  <= in_range;
      s1_idx_q  <= idx;
    end
    fwd_idx_q  <= s1_idx_q;
    fwd_data_q <= rsp.entry;
    if (s1_vld_q) begin
      res_q <= rsp;
    end
  end

  assign done_o         = done_q;
  assign status_o       = res_q.status;
  assign lifecycle_o    = res_q.entry.lc;
  assign current_tier_o = res_q.entry.cur;
  assign target_tier_o  = res_q.entry.tgt;
  assign usage_count_o  = res_q.entry.usage;
  assign last_used_o    = res_q.entry.last;
  assign registered_o   = res_q.entry.valid;

endmodule

/* sv/erst_checker.sv */
// erst_checker: port-level assertions for the residency table, bound to the top
// depends on erst_pkg and expert_residency_state_table

module erst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [erst_pkg::OP_W-1:0]     opcode_i,
  input logic                          done_o,
  input logic [erst_pkg::STAT_W-1:0]   status_o,
  input logic [erst_pkg::LC_W-1:0]     lifecycle_o,
  input logic [erst_pkg::CNT_W-1:0]    usage_count_o,
  input logic                          registered_o
);
  import erst_pkg::*;

  // every accepted word yields a result strobe from the result register
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("missing result for accepted word");

  // no result without an earlier accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without accepted word");

  // a not-registered result carries an empty entry
  a_not_reg_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_NOT_REG) |-> (!registered_o && usage_count_o == '0))
    else $error("not-registered result with entry fields");

  // any other status reports a valid entry
  a_valid_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_NOT_REG) |-> registered_o)
    else $error("entry not valid on a registered result");

  // a successful acquire leaves the expert in use
  a_acquire_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_OK && $past(opcode_i, 2) == OP_ACQUIRE)
      |-> (lifecycle_o == LC_IN_USE))
    else $error("acquire did not reach in-use");

endmodule

bind expert_residency_state_table erst_checker u_erst_checker (.*);

/* tb/expert_residency_state_table_test.sv */
// expert_residency_state_table_test: self-checking bench for the residency table
// depends on erst_pkg and expert_residency_state_table; a directed table, then
// lifecycle-aware random commands, each result checked against a typed expectation or an entry predictor
`timescale 1ns / 100ps

module expert_residency_state_table_test;
  import erst_pkg::*;

  localparam logic [OP_W-1:0]     OP_UNDEF_LO = 4'd10;
  localparam logic [OP_W-1:0]     OP_UNDEF_HI = 4'd15;
  localparam logic [LAYER_W-1:0]  LAST_LAYER  = LAYER_W'(NUM_LAYERS - 1);
  localparam logic [EXPERT_W-1:0] LAST_EXPERT = EXPERT_W'(NUM_EXPERTS - 1);
  localparam logic [TIER_W-1:0]   TIER_MAX    = TIER_W'(NUM_TIERS - 1);
  localparam logic [TIME_W-1:0]   TIME_MAX    = '1;
  localparam int RANDOM_CMDS = 900;
  localparam int QUIET_CMDS  = 150;
  localparam int POOL_N      = 12;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LAYER_W-1:0]  layer;
    logic [EXPERT_W-1:0] expert;
    logic [TIER_W-1:0]   tier;
    logic [TIME_W-1:0]   now;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    lc_e                 lc;
    logic [TIER_W-1:0]   cur;
    logic [TIER_W-1:0]   tgt;
    logic [CNT_W-1:0]    usage;
    logic [TIME_W-1:0]   last;
    logic                registered;
  } res_t;

  typedef struct packed {
    cmd_t cmd;
    logic typed;
    res_t res;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     opcode_i;
  logic [LAYER_W-1:0]  layer_i;
  logic [EXPERT_W-1:0] expert_i;
  logic [TIER_W-1:0]   tier_i;
  logic [TIME_W-1:0]   now_i;
  logic                done_o;
  logic [STAT_W-1:0]   status_o;
  logic [LC_W-1:0]     lifecycle_o;
  logic [TIER_W-1:0]   current_tier_o;
  logic [TIER_W-1:0]   target_tier_o;
  logic [CNT_W-1:0]    usage_count_o;
  logic [TIME_W-1:0]   last_used_o;
  logic                registered_o;

  // shadow copy of the table
  bit                tbl_valid [DEPTH];
  lc_e               tbl_lc    [DEPTH];
  logic [TIER_W-1:0] tbl_cur   [DEPTH];
  logic [TIER_W-1:0] tbl_tgt   [DEPTH];
  logic [CNT_W-1:0]  tbl_usage [DEPTH];
  logic [TIME_W-1:0] tbl_last  [DEPTH];

  res_t pending_results[$];
  row_t directed_tbl[$];
  int   mismatch_cnt = 0;

  expert_residency_state_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .layer_i        (layer_i),
    .expert_i       (expert_i),
    .tier_i         (tier_i),
    .now_i          (now_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .lifecycle_o    (lifecycle_o),
    .current_tier_o (current_tier_o),
    .target_tier_o  (target_tier_o),
    .usage_count_o  (usage_count_o),
    .last_used_o    (last_used_o),
    .registered_o   (registered_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic res_t apply_residency_op(input cmd_t c);
    res_t r;
    int idx;
    logic [TIER_W-1:0] t;
    r = '0;
    r.status = ST_NOT_REG;
    t = (32'(c.tier) >= NUM_TIERS) ? TIER_MAX : c.tier;
    if (32'(c.layer) >= NUM_LAYERS || 32'(c.expert) >= NUM_EXPERTS) return r;
    idx = int'(c.layer) * NUM_EXPERTS + int'(c.expert);
    if (c.op != OP_REGISTER && !tbl_valid[idx]) return r;
    r.status = ST_OK;
    if (c.op == OP_REGISTER) begin
      if (tbl_valid[idx]) begin
        r.status = ST_ALREADY;
      end else begin
        tbl_valid[idx] = 1'b1;
        tbl_lc[idx]    = LC_READY;
        tbl_cur[idx]   = t;
        tbl_tgt[idx]   = t;
        tbl_usage[idx] = '0;
        tbl_last[idx]  = c.now;
      end
    end else begin
      case (c.op)
        OP_REQUEST: begin
          if (tbl_lc[idx] == LC_READY || tbl_lc[idx] == LC_FAILED) begin
            tbl_tgt[idx] = t;
            tbl_lc[idx]  = LC_REQUESTED;
          end else r.status = ST_ILLEGAL;
        end
        OP_QUEUE: begin
          if (tbl_lc[idx] == LC_REQUESTED) tbl_lc[idx] = LC_QUEUED;
          else r.status = ST_ILLEGAL;
        end
        OP_LOAD: begin
          if (tbl_lc[idx] == LC_QUEUED) tbl_lc[idx] = LC_LOADING;
          else r.status = ST_ILLEGAL;
        end
        OP_READY: begin
          if (tbl_lc[idx] inside {LC_LOADING, LC_EVICTING, LC_REQUESTED}) begin
            tbl_cur[idx]  = t;
            tbl_tgt[idx]  = t;
            tbl_lc[idx]   = LC_READY;
            tbl_last[idx] = c.now;
          end else r.status = ST_ILLEGAL;
        end
        OP_ACQUIRE: begin
          if (tbl_lc[idx] == LC_READY) begin
            tbl_lc[idx]   = LC_IN_USE;
            tbl_last[idx] = c.now;
            // usage count sticks at all ones
            if (tbl_usage[idx] != '1) tbl_usage[idx] = tbl_usage[idx] + 1'b1;
          end else r.status = ST_ILLEGAL;
        end
        OP_RELEASE: begin
          if (tbl_lc[idx] == LC_IN_USE) begin
            tbl_lc[idx]   = LC_READY;
            tbl_last[idx] = c.now;
          end else r.status = ST_ILLEGAL;
        end
        OP_EVICT: begin
          if (tbl_lc[idx] == LC_READY) begin
            tbl_tgt[idx] = t;
            tbl_lc[idx]  = LC_EVICTING;
          end else r.status = ST_ILLEGAL;
        end
        OP_FAIL: tbl_lc[idx] = LC_FAILED;
        default: ; // read and the undefined codes leave the entry alone
      endcase
    end
    r.lc         = tbl_lc[idx];
    r.cur        = tbl_cur[idx];
    r.tgt        = tbl_tgt[idx];
    r.usage      = tbl_usage[idx];
    r.last       = tbl_last[idx];
    r.registered = tbl_valid[idx];
    return r;
  endfunction

  // mostly the next legal step of the entry's lifecycle, sometimes anything
  function automatic logic [OP_W-1:0] pick_lifecycle_op(input logic [LAYER_W-1:0] layer,
                                                       input logic [EXPERT_W-1:0] expert);
    int idx;
    int roll;
    idx  = int'(layer) * NUM_EXPERTS + int'(expert);
    roll = $urandom_range(0, 99);
    if (roll < 8) return OP_W'($urandom_range(0, 15));
    if (!tbl_valid[idx]) return OP_REGISTER;
    case (tbl_lc[idx])
      LC_READY: begin
        if (roll < 45) return OP_ACQUIRE;
        if (roll < 65) return OP_REQUEST;
        if (roll < 85) return OP_EVICT;
        if (roll < 92) return OP_READ;
        return OP_FAIL;
      end
      LC_REQUESTED: begin
        if (roll < 70) return OP_QUEUE;
        if (roll < 90) return OP_READY;
        return OP_FAIL;
      end
      LC_QUEUED:   return (roll < 95) ? OP_LOAD : OP_FAIL;
      LC_LOADING:  return (roll < 95) ? OP_READY : OP_FAIL;
      LC_IN_USE:   return (roll < 95) ? OP_RELEASE : OP_FAIL;
      LC_EVICTING: return (roll < 95) ? OP_READY : OP_FAIL;
      default:     return (roll < 85) ? OP_REQUEST : OP_FAIL;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < 100)
      $display("mismatch on %s at %0t: got %0h, want %0h", field, $realtime, got, want);
    mismatch_cnt++;
  endtask

  task automatic add_row(input row_t r);
    directed_tbl.insert(directed_tbl.size(), r);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  task automatic issue_command(input cmd_t c, input logic typed, input res_t typed_res);
    res_t predicted;
    start    <= 1'b1;
    opcode_i <= c.op;
    layer_i  <= c.layer;
    expert_i <= c.expert;
    tier_i   <= c.tier;
    now_i    <= c.now;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = apply_residency_op(c);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 32'(status_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (lifecycle_o !== want.lc)
          report_mismatch("lifecycle", 32'(lifecycle_o), 32'(want.lc));
        if (current_tier_o !== want.cur)
          report_mismatch("current_tier", 32'(current_tier_o), 32'(want.cur));
        if (target_tier_o !== want.tgt)
          report_mismatch("target_tier", 32'(target_tier_o), 32'(want.tgt));
        if (usage_count_o !== want.usage)
          report_mismatch("usage_count", usage_count_o, want.usage);
        if (last_used_o !== want.last) report_mismatch("last_used", last_used_o, want.last);
        if (registered_o !== want.registered)
          report_mismatch("registered", 32'(registered_o), 32'(want.registered));
      end
    end
  end

  initial begin : stimulus
    cmd_t c;
    logic [LAYER_W-1:0]  pool_layer  [POOL_N];
    logic [EXPERT_W-1:0] pool_expert [POOL_N];
    int k;
    start    <= 1'b0;
    opcode_i <= OP_READ;
    layer_i  <= '0;
    expert_i <= '0;
    tier_i   <= '0;
    now_i    <= '0;
    rst_ni   <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni   <= 1'b1;

    // op, layer, expert, tier, now | typed | status, lifecycle, cur, tgt, usage, last, reg
    add_row('{'{OP_READ, LAST_LAYER, LAST_EXPERT, 2'd0, 32'd0}, 1'b1,
              '{ST_NOT_REG, LC_READY, 2'd0, 2'd0, 32'd0, 32'd0, 1'b0}});
    add_row('{'{OP_ACQUIRE, 5'd0, 6'd0, 2'd0, 32'd9}, 1'b1,
              '{ST_NOT_REG, LC_READY, 2'd0, 2'd0, 32'd0, 32'd0, 1'b0}});
    add_row('{'{OP_REGISTER, 5'd0, 6'd0, TIER_MAX, TIME_MAX}, 1'b1,
              '{ST_OK, LC_READY, TIER_MAX, TIER_MAX, 32'd0, TIME_MAX, 1'b1}});
    // double registration keeps the first contents
    add_row('{'{OP_REGISTER, 5'd0, 6'd0, 2'd0, 32'd0}, 1'b1,
              '{ST_ALREADY, LC_READY, TIER_MAX, TIER_MAX, 32'd0, TIME_MAX, 1'b1}});
    add_row('{'{OP_QUEUE, 5'd0, 6'd0, 2'd1, 32'd0}, 1'b1,
              '{ST_ILLEGAL, LC_READY, TIER_MAX, TIER_MAX, 32'd0, TIME_MAX, 1'b1}});
    add_row('{'{OP_ACQUIRE, 5'd0, 6'd0, 2'd0, 32'd1}, 1'b0, '0});
    add_row('{'{OP_ACQUIRE, 5'd0, 6'd0, 2'd0, 32'd2}, 1'b0, '0});
    add_row('{'{OP_RELEASE, 5'd0, 6'd0, 2'd0, 32'd3}, 1'b0, '0});
    add_row('{'{OP_REQUEST, 5'd0, 6'd0, 2'd1, 32'd4}, 1'b0, '0});
    add_row('{'{OP_QUEUE, 5'd0, 6'd0, 2'd2, 32'd5}, 1'b0, '0});
    add_row('{'{OP_LOAD, 5'd0, 6'd0, 2'd2, 32'd6}, 1'b0, '0});
    add_row('{'{OP_READY, 5'd0, 6'd0, 2'd1, 32'd7}, 1'b0, '0});
    add_row('{'{OP_EVICT, 5'd0, 6'd0, 2'd2, 32'd8}, 1'b0, '0});
    add_row('{'{OP_READY, 5'd0, 6'd0, 2'd2, 32'd9}, 1'b0, '0});
    add_row('{'{OP_REQUEST, 5'd0, 6'd0, 2'd0, 32'd10}, 1'b0, '0});
    // requested straight back to ready
    add_row('{'{OP_READY, 5'd0, 6'd0, 2'd0, 32'd11}, 1'b0, '0});
    add_row('{'{OP_FAIL, 5'd0, 6'd0, 2'd3, 32'd12}, 1'b0, '0});
    add_row('{'{OP_REQUEST, 5'd0, 6'd0, TIER_MAX, TIME_MAX}, 1'b0, '0});
    add_row('{'{OP_UNDEF_HI, 5'd0, 6'd0, TIER_MAX, TIME_MAX}, 1'b0, '0});
    add_row('{'{OP_UNDEF_LO, 5'd0, 6'd0, 2'd0, 32'd0}, 1'b0, '0});
    add_row('{'{OP_READ, 5'd0, 6'd0, 2'd1, 32'd13}, 1'b0, '0});
    add_row('{'{OP_REGISTER, LAST_LAYER, LAST_EXPERT, 2'd0, 32'd0}, 1'b1,
              '{ST_OK, LC_READY, 2'd0, 2'd0, 32'd0, 32'd0, 1'b1}});
    add_row('{'{OP_RELEASE, LAST_LAYER, LAST_EXPERT, 2'd1, 32'd5}, 1'b1,
              '{ST_ILLEGAL, LC_READY, 2'd0, 2'd0, 32'd0, 32'd0, 1'b1}});
    add_row('{'{OP_FAIL, LAST_LAYER, LAST_EXPERT, 2'd2, 32'd6}, 1'b0, '0});
    add_row('{'{OP_ACQUIRE, LAST_LAYER, LAST_EXPERT, 2'd2, 32'd7}, 1'b0, '0});

    foreach (directed_tbl[i]) begin
      if ($urandom_range(0, 2) == 0) idle_burst();
      issue_command(directed_tbl[i].cmd, directed_tbl[i].typed, directed_tbl[i].res);
    end

    // a few hot entries carry the lifecycle sequences, corners among them
    pool_layer[0] = '0;         pool_expert[0] = '0;
    pool_layer[1] = LAST_LAYER; pool_expert[1] = LAST_EXPERT;
    pool_layer[2] = LAST_LAYER; pool_expert[2] = '0;
    pool_layer[3] = '0;         pool_expert[3] = LAST_EXPERT;
    for (int p = 4; p < POOL_N; p++) begin
      pool_layer[p]  = LAYER_W'($urandom_range(0, NUM_LAYERS - 1));
      pool_expert[p] = EXPERT_W'($urandom_range(0, NUM_EXPERTS - 1));
    end

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if ($urandom_range(0, 9) < 8) begin
        k        = $urandom_range(0, POOL_N - 1);
        c.layer  = pool_layer[k];
        c.expert = pool_expert[k];
        c.op     = pick_lifecycle_op(c.layer, c.expert);
      end else begin
        c.op     = OP_W'($urandom_range(0, 15));
        c.layer  = LAYER_W'($urandom_range(0, NUM_LAYERS - 1));
        c.expert = EXPERT_W'($urandom_range(0, NUM_EXPERTS - 1));
      end
      c.tier = TIER_W'($urandom_range(0, 3));
      c.now  = $urandom;
      // idle in bursts, then a stretch at full rate
      if (n < RANDOM_CMDS - QUIET_CMDS && $urandom_range(0, 3) == 0) idle_burst();
      issue_command(c, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
